// ----- rtl/core/pwsa_pkg.sv -----
// shared types, constants and sine table for the plasma warp source address unit
`default_nettype none
package pwsa_pkg;

    localparam int CoordBits    = 12;
    localparam int DimBits      = 13;
    localparam int PhaseBits    = 9;
    localparam int TableSize    = 512;
    localparam int QuarterSize  = TableSize / 4;
    localparam int SineBits     = 12;
    localparam int WaveBits     = 13;
    localparam int AmpBits      = 7;
    localparam int DispBits     = 8;
    localparam int PosBits      = 14;
    localparam int ScaleShift   = 11;
    localparam int AmpMin       = 2;
    localparam int AmpMax       = 96;
    localparam int DimMax       = 1 << CoordBits;
    localparam int AddrBits     = 24;
    localparam int TaylorTerms  = 12;
    localparam logic [63:0] PiQ30 = 64'd3373259426;

    typedef enum logic [2:0] {
        RegFreqX       = 3'd0,
        RegFreqY       = 3'd1,
        RegGridBend    = 3'd2,
        RegGridTwist   = 3'd3,
        RegPhaseSpeed  = 3'd4,
        RegPhaseDrift  = 3'd5,
        RegFrameWidth  = 3'd6,
        RegFrameHeight = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]         freq_x;
        logic [7:0]         freq_y;
        logic [7:0]         grid_bend;
        logic [7:0]         grid_twist;
        logic [7:0]         phase_speed;
        logic [7:0]         phase_drift;
        logic [AmpBits-1:0] amp_x;
        logic [AmpBits-1:0] amp_y;
    } t_wave_cfg;

    typedef struct packed {
        logic [DimBits-1:0]   period;
        logic [CoordBits-1:0] last;
        logic                 small_dim;
    } t_axis_geo;

    typedef logic [10:0] t_qtab [0:QuarterSize];

    // round(1024*sin) of the first quadrant, fixed-point taylor series
    function automatic logic [10:0] quarter_sine(input logic [7:0] k);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x    = ({56'd0, k} * PiQ30 * 64'd2) / 64'(TableSize);
        term = x;
        acc  = $signed(x);
        for (int n = 1; n <= TaylorTerms; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        return 11'((64'(acc) + 64'd524288) >> 20);
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int i = 0; i <= QuarterSize; i++) begin
            t[i] = quarter_sine(8'(i));
        end
        return t;
    endfunction

    localparam t_qtab QuarterTab = build_qtab();

    // full-circle lookup folded onto the quarter table
    function automatic logic signed [SineBits-1:0] sine_lookup(input logic [PhaseBits-1:0] idx);
        logic [7:0]  r;
        logic [10:0] v;
        r = {1'b0, idx[6:0]};
        v = idx[7] ? QuarterTab[8'(QuarterSize) - r] : QuarterTab[r];
        return idx[8] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pwsa_wave.sv -----
// phase indices, sine sums, amplitude scaling and displaced position
`default_nettype none
module pwsa_wave (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_vld,
    input  wire logic [pwsa_pkg::CoordBits-1:0]      i_x,
    input  wire logic [pwsa_pkg::CoordBits-1:0]      i_y,
    input  wire logic                                i_fe,
    input  wire pwsa_pkg::t_wave_cfg                 i_cfg,
    output logic                                     o_vld,
    output logic signed [pwsa_pkg::PosBits-1:0]      o_vx,
    output logic signed [pwsa_pkg::PosBits-1:0]      o_vy,
    output logic                                     o_fe
);

    localparam int PB = pwsa_pkg::PhaseBits;
    localparam int CB = pwsa_pkg::CoordBits;
    localparam int WB = pwsa_pkg::WaveBits;
    localparam int DB = pwsa_pkg::DispBits;
    localparam int PrB = (WB - 1) + pwsa_pkg::AmpBits;

    logic [PB-1:0] r_phase_one, r_phase_two;

    logic          r_s1_vld, r_s1_fe;
    logic [PB-1:0] r_s1_idx [4];
    logic [CB-1:0] r_s1_x, r_s1_y;
    logic [PB-1:0] n_idx [4];

    logic                 r_s2_vld, r_s2_fe;
    logic signed [WB-1:0] r_s2_wx, r_s2_wy;
    logic [CB-1:0]        r_s2_x, r_s2_y;
    logic signed [pwsa_pkg::SineBits-1:0] n_sin [4];

    logic          r_s3_vld, r_s3_fe;
    logic [DB-1:0] r_s3_dx, r_s3_dy;
    logic          r_s3_nx, r_s3_ny;
    logic [CB-1:0] r_s3_x, r_s3_y;
    logic [WB-2:0] n_magx, n_magy;
    logic [PrB-1:0] n_prodx, n_prody;

    logic                               r_s4_vld, r_s4_fe;
    logic signed [pwsa_pkg::PosBits-1:0] r_s4_vx, r_s4_vy;

    always_comb begin
        n_idx[0] = r_phase_one + PB'(i_y * i_cfg.grid_bend) + PB'(i_x * i_cfg.freq_x);
        n_idx[1] = r_phase_one + PB'(i_y * i_cfg.grid_twist);
        n_idx[2] = r_phase_two + PB'(i_y * i_cfg.grid_twist) + PB'(i_x * i_cfg.freq_y);
        n_idx[3] = r_phase_two + PB'(i_y * i_cfg.grid_bend);
        for (int i = 0; i < 4; i++) begin
            n_sin[i] = pwsa_pkg::sine_lookup(r_s1_idx[i]);
        end
        n_magx  = r_s2_wx[WB-1] ? (WB-1)'(-r_s2_wx) : (WB-1)'(r_s2_wx);
        n_magy  = r_s2_wy[WB-1] ? (WB-1)'(-r_s2_wy) : (WB-1)'(r_s2_wy);
        n_prodx = PrB'(n_magx) * PrB'(i_cfg.amp_x);
        n_prody = PrB'(n_magy) * PrB'(i_cfg.amp_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_one <= '0;
            r_phase_two <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
        end else begin
            if (i_vld && i_fe) begin
                r_phase_one <= r_phase_one + PB'(i_cfg.phase_speed);
                r_phase_two <= r_phase_two + PB'(i_cfg.phase_drift);
            end
            if (i_en) begin
                r_s1_vld <= i_vld;
                r_s2_vld <= r_s1_vld;
                r_s3_vld <= r_s2_vld;
                r_s4_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_idx <= n_idx;
            r_s1_x   <= i_x;
            r_s1_y   <= i_y;
            r_s1_fe  <= i_fe;

            r_s2_wx <= WB'(n_sin[0]) + WB'(n_sin[1]);
            r_s2_wy <= WB'(n_sin[2]) + WB'(n_sin[3]);
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
            r_s2_fe <= r_s1_fe;

            r_s3_dx <= n_prodx[PrB-1:pwsa_pkg::ScaleShift];
            r_s3_dy <= n_prody[PrB-1:pwsa_pkg::ScaleShift];
            r_s3_nx <= r_s2_wx[WB-1];
            r_s3_ny <= r_s2_wy[WB-1];
            r_s3_x  <= r_s2_x;
            r_s3_y  <= r_s2_y;
            r_s3_fe <= r_s2_fe;

            r_s4_vx <= r_s3_nx ? $signed({2'b00, r_s3_x}) - $signed({6'd0, r_s3_dx})
                               : $signed({2'b00, r_s3_x}) + $signed({6'd0, r_s3_dx});
            r_s4_vy <= r_s3_ny ? $signed({2'b00, r_s3_y}) - $signed({6'd0, r_s3_dy})
                               : $signed({2'b00, r_s3_y}) + $signed({6'd0, r_s3_dy});
            r_s4_fe <= r_s3_fe;
        end
    end

    assign o_vld = r_s4_vld;
    assign o_vx  = r_s4_vx;
    assign o_vy  = r_s4_vy;
    assign o_fe  = r_s4_fe;

endmodule
`default_nettype wire

// ----- rtl/core/pwsa_reflect.sv -----
// pipelined remainder by the mirror period and fold into the frame, both axes
`default_nettype none
module pwsa_reflect (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_vld,
    input  wire logic signed [pwsa_pkg::PosBits-1:0] i_vx,
    input  wire logic signed [pwsa_pkg::PosBits-1:0] i_vy,
    input  wire logic                                i_fe,
    input  wire pwsa_pkg::t_axis_geo                 i_geo_x,
    input  wire pwsa_pkg::t_axis_geo                 i_geo_y,
    output logic                                     o_vld,
    output logic [pwsa_pkg::CoordBits-1:0]           o_sx,
    output logic [pwsa_pkg::CoordBits-1:0]           o_sy,
    output logic                                     o_fe
);

    localparam int DivBits   = pwsa_pkg::DimBits;
    localparam int PerStage  = 3;
    localparam int RemStages = (DivBits + PerStage - 1) / PerStage;
    localparam int CB        = pwsa_pkg::CoordBits;

    pwsa_pkg::t_axis_geo geo [2];
    logic signed [pwsa_pkg::PosBits-1:0] vin [2];

    logic               r_vld [RemStages];
    logic               r_fe  [RemStages];
    logic [DivBits-1:0] r_mag [RemStages][2];
    logic [DivBits-1:0] r_rem [RemStages][2];
    logic               r_neg [RemStages][2];

    logic [DivBits-1:0] n_mag [RemStages][2];
    logic [DivBits-1:0] n_rem [RemStages][2];
    logic               n_neg [RemStages][2];
    logic [CB-1:0]      n_s   [2];

    logic [DivBits:0]   rem;
    logic [DivBits-1:0] r_fold;

    logic          r_out_vld, r_out_fe;
    logic [CB-1:0] r_sx, r_sy;

    assign geo[0] = i_geo_x;
    assign geo[1] = i_geo_y;
    assign vin[0] = i_vx;
    assign vin[1] = i_vy;

    always_comb begin
        rem    = '0;
        r_fold = '0;
        for (int s = 0; s < RemStages; s++) begin
            for (int a = 0; a < 2; a++) begin
                if (s == 0) begin
                    n_neg[s][a] = vin[a] < 0;
                    n_mag[s][a] = (vin[a] < 0) ? DivBits'(-vin[a]) : DivBits'(vin[a]);
                    rem         = '0;
                end else begin
                    n_neg[s][a] = r_neg[s-1][a];
                    n_mag[s][a] = r_mag[s-1][a];
                    rem         = {1'b0, r_rem[s-1][a]};
                end
                for (int j = 0; j < PerStage; j++) begin
                    if (s * PerStage + j < DivBits) begin
                        rem = {rem[DivBits-1:0],
                               n_mag[s][a][4'(DivBits - 1 - (s * PerStage + j))]};
                        if (rem >= {1'b0, geo[a].period}) begin
                            rem = rem - {1'b0, geo[a].period};
                        end
                    end
                end
                n_rem[s][a] = rem[DivBits-1:0];
            end
        end
        for (int a = 0; a < 2; a++) begin
            if (r_neg[RemStages-1][a] && (r_rem[RemStages-1][a] != '0)) begin
                r_fold = geo[a].period - r_rem[RemStages-1][a];
            end else begin
                r_fold = r_rem[RemStages-1][a];
            end
            if (r_fold > {1'b0, geo[a].last}) begin
                r_fold = geo[a].period - r_fold;
            end
            n_s[a] = geo[a].small_dim ? '0 : CB'(r_fold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RemStages; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < RemStages; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_out_vld <= r_vld[RemStages-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fe[0] <= i_fe;
            for (int s = 1; s < RemStages; s++) begin
                r_fe[s] <= r_fe[s-1];
            end
            r_mag    <= n_mag;
            r_rem    <= n_rem;
            r_neg    <= n_neg;
            r_sx     <= n_s[0];
            r_sy     <= n_s[1];
            r_out_fe <= r_fe[RemStages-1];
        end
    end

    assign o_vld = r_out_vld;
    assign o_sx  = r_sx;
    assign o_sy  = r_sy;
    assign o_fe  = r_out_fe;

endmodule
`default_nettype wire

// ----- rtl/core/plasma_warp_source_address_unit.sv -----
// top level: register port, wave and reflect pipelines, address output stage
//
//  channel  | direction | contents
//  s_*      | in        | tdata = dest_x, dest_y; tlast = frame_end
//  m_*      | out       | tdata = source_x, source_y, source_address; tlast = frame_done
//  apb      | in/out    | eight setup registers at 4*i
//
// one item per clock while the pipeline moves; 4 wave stages, 5 remainder stages
// (3 divide steps each, 1 in the last), fold stage and address output register
// the whole pipeline moves as one while the output register is empty or taken
// synchronous reset clears valid bits, phases and registers to their defaults
// both phases advance when a transaction with tlast is accepted
`default_nettype none
module plasma_warp_source_address_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // dest_x, dest_y
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // source_x, source_y, source_address
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CB = pwsa_pkg::CoordBits;
    localparam int DB = pwsa_pkg::DimBits;

    logic [7:0]    r_freq_x, r_freq_y, r_grid_bend, r_grid_twist;
    logic [7:0]    r_phase_speed, r_phase_drift;
    logic [DB-1:0] r_frame_width, r_frame_height;

    logic [DB-1:0] w_eff, h_eff;
    logic [8:0]    w_sh, h_sh;
    logic [pwsa_pkg::AmpBits-1:0] amp_x, amp_y;
    pwsa_pkg::t_wave_cfg wave_cfg;
    pwsa_pkg::t_axis_geo geo_x, geo_y;

    logic en, acc, cfg_wr;

    logic wv_vld, wv_fe;
    logic signed [pwsa_pkg::PosBits-1:0] wv_vx, wv_vy;
    logic          rf_vld, rf_fe;
    logic [CB-1:0] rf_sx, rf_sy;

    logic          r_m_vld, r_m_last;
    logic [CB-1:0] r_sx, r_sy;
    logic [pwsa_pkg::AddrBits-1:0] r_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_x       <= 8'd5;
            r_freq_y       <= 8'd3;
            r_grid_bend    <= 8'd3;
            r_grid_twist   <= 8'd1;
            r_phase_speed  <= 8'd9;
            r_phase_drift  <= 8'd8;
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
        end else if (cfg_wr) begin
            unique case (pwsa_pkg::t_reg_idx'(paddr[4:2]))
                pwsa_pkg::RegFreqX:       r_freq_x       <= pwdata[7:0];
                pwsa_pkg::RegFreqY:       r_freq_y       <= pwdata[7:0];
                pwsa_pkg::RegGridBend:    r_grid_bend    <= pwdata[7:0];
                pwsa_pkg::RegGridTwist:   r_grid_twist   <= pwdata[7:0];
                pwsa_pkg::RegPhaseSpeed:  r_phase_speed  <= pwdata[7:0];
                pwsa_pkg::RegPhaseDrift:  r_phase_drift  <= pwdata[7:0];
                pwsa_pkg::RegFrameWidth:  r_frame_width  <= pwdata[DB-1:0];
                pwsa_pkg::RegFrameHeight: r_frame_height <= pwdata[DB-1:0];
                default:                  r_freq_x       <= r_freq_x;
            endcase
        end
    end

    always_comb begin
        unique case (pwsa_pkg::t_reg_idx'(paddr[4:2]))
            pwsa_pkg::RegFreqX:       prdata = {24'd0, r_freq_x};
            pwsa_pkg::RegFreqY:       prdata = {24'd0, r_freq_y};
            pwsa_pkg::RegGridBend:    prdata = {24'd0, r_grid_bend};
            pwsa_pkg::RegGridTwist:   prdata = {24'd0, r_grid_twist};
            pwsa_pkg::RegPhaseSpeed:  prdata = {24'd0, r_phase_speed};
            pwsa_pkg::RegPhaseDrift:  prdata = {24'd0, r_phase_drift};
            pwsa_pkg::RegFrameWidth:  prdata = {19'd0, r_frame_width};
            pwsa_pkg::RegFrameHeight: prdata = {19'd0, r_frame_height};
            default:                  prdata = '0;
        endcase
    end

    // frame geometry and amplitudes follow the setup registers
    always_comb begin
        w_eff = (r_frame_width  > DB'(pwsa_pkg::DimMax)) ? DB'(pwsa_pkg::DimMax) : r_frame_width;
        h_eff = (r_frame_height > DB'(pwsa_pkg::DimMax)) ? DB'(pwsa_pkg::DimMax) : r_frame_height;
        w_sh  = w_eff[DB-1:4];
        h_sh  = h_eff[DB-1:4];
        if (w_sh < 9'(pwsa_pkg::AmpMin)) begin
            amp_x = pwsa_pkg::AmpBits'(pwsa_pkg::AmpMin);
        end else if (w_sh > 9'(pwsa_pkg::AmpMax)) begin
            amp_x = pwsa_pkg::AmpBits'(pwsa_pkg::AmpMax);
        end else begin
            amp_x = w_sh[pwsa_pkg::AmpBits-1:0];
        end
        if (h_sh < 9'(pwsa_pkg::AmpMin)) begin
            amp_y = pwsa_pkg::AmpBits'(pwsa_pkg::AmpMin);
        end else if (h_sh > 9'(pwsa_pkg::AmpMax)) begin
            amp_y = pwsa_pkg::AmpBits'(pwsa_pkg::AmpMax);
        end else begin
            amp_y = h_sh[pwsa_pkg::AmpBits-1:0];
        end
        geo_x.last      = CB'(w_eff - 13'd1);
        geo_x.period    = {geo_x.last, 1'b0};
        geo_x.small_dim = w_eff <= 13'd1;
        geo_y.last      = CB'(h_eff - 13'd1);
        geo_y.period    = {geo_y.last, 1'b0};
        geo_y.small_dim = h_eff <= 13'd1;
        wave_cfg.freq_x      = r_freq_x;
        wave_cfg.freq_y      = r_freq_y;
        wave_cfg.grid_bend   = r_grid_bend;
        wave_cfg.grid_twist  = r_grid_twist;
        wave_cfg.phase_speed = r_phase_speed;
        wave_cfg.phase_drift = r_phase_drift;
        wave_cfg.amp_x       = amp_x;
        wave_cfg.amp_y       = amp_y;
    end

    assign en       = !r_m_vld || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;

    pwsa_wave u_wave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (acc),
        .i_x     (s_tdata[11:0]),
        .i_y     (s_tdata[23:12]),
        .i_fe    (s_tlast),
        .i_cfg   (wave_cfg),
        .o_vld   (wv_vld),
        .o_vx    (wv_vx),
        .o_vy    (wv_vy),
        .o_fe    (wv_fe)
    );

    pwsa_reflect u_reflect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (wv_vld),
        .i_vx    (wv_vx),
        .i_vy    (wv_vy),
        .i_fe    (wv_fe),
        .i_geo_x (geo_x),
        .i_geo_y (geo_y),
        .o_vld   (rf_vld),
        .o_sx    (rf_sx),
        .o_sy    (rf_sy),
        .o_fe    (rf_fe)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= rf_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx     <= rf_sx;
            r_sy     <= rf_sy;
            r_addr   <= pwsa_pkg::AddrBits'(rf_sy) * pwsa_pkg::AddrBits'(w_eff)
                      + pwsa_pkg::AddrBits'(rf_sx);
            r_m_last <= rf_fe;
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tdata  = {r_addr, r_sy, r_sx};
    assign m_tlast  = r_m_last;

`ifndef SYNTH
    a_sx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_vld |-> (geo_x.small_dim ? (r_sx == '0) : (r_sx <= geo_x.last)))
        else $error("source x outside frame");

    a_sy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_vld |-> (geo_y.small_dim ? (r_sy == '0) : (r_sy <= geo_y.last)))
        else $error("source y outside frame");

    a_addr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_vld |-> (r_addr == pwsa_pkg::AddrBits'(r_sy * w_eff + 25'(r_sx))))
        else $error("source address does not match coordinates");
`endif

endmodule
`default_nettype wire
